// ===== src/pbt_pkg.sv =====
// Shared types for the band-limited triangle oscillator.
// Holds the controller state enum and the control/status structs.
// No dependencies.
package pbt_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_DIV,
		ST_SQ,
		ST_MIX,
		ST_MUL,
		ST_WRITE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_tick;
		logic load_reset;
		logic edge_start;
		logic edge_sel;
		logic div_step;
		logic sq_acc;
		logic mix;
		logic mul;
		logic commit;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic rst_cmd;
		logic edge_hit;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// ===== src/pbt_if.sv =====
// Valid/ready channel interfaces for the triangle oscillator.
// pbt_item_if carries command items in, pbt_sample_if carries samples out.
// No dependencies.
interface pbt_item_if #(
	parameter int PHASE_BITS = 24
);
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [PHASE_BITS-1:0] phase_step;
	logic [PHASE_BITS-1:0] new_phase;

	modport source (output valid, output cmd, output phase_step, output new_phase, input ready);
	modport sink (input valid, input cmd, input phase_step, input new_phase, output ready);
endinterface

interface pbt_sample_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== src/polyblep_triangle_oscillator.sv =====
// Top level of the band-limited triangle oscillator.
// Depends on pbt_pkg, pbt_item_if, pbt_sample_if, pbt_ctrl and pbt_dp.
//
//   Port      Dir   Payload                                  Handshake
//   items     sink  cmd, phase_step, new_phase (Q0.P)        valid/ready
//   samples   src   sample (signed Q3.(S-3), saturated)      valid/ready
//
// A reset item (cmd = 1) loads the phase, clears the integrator and gives
// no sample. A tick tests both edges in turn; each edge that needs a
// PolyBLEP correction runs the shared restoring divider, which produces
// one quotient bit per cycle, and then a squaring step. The tick then
// mixes, multiplies and writes the sample. The finished sample sits in an
// output register, so the next item is accepted while it waits; a full
// register stalls only the final write of the following tick.
// Asynchronous reset clears the phase, integrator and output valid.
module polyblep_triangle_oscillator #(
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	pbt_item_if.sink     items,
	pbt_sample_if.source samples
);
	import pbt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequencer: accepts items only between ticks, steps the datapath
	pbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// Datapath: state, edge tests, divider, squarer, integrator, output
	pbt_dp #(
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (items.cmd),
		.phase_step (items.phase_step),
		.new_phase  (items.new_phase),
		.out_valid  (samples.valid),
		.out_ready  (samples.ready),
		.sample     (samples.sample)
	);

endmodule

// ===== src/pbt_ctrl.sv =====
// Sequencing state machine for the triangle oscillator.
// Depends on pbt_pkg for state_t, ctl_t and sts_t.
module pbt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output pbt_pkg::ctl_t ctl,
	input  pbt_pkg::sts_t sts
);
	import pbt_pkg::*;

	state_t state_q, state_d;
	logic   edge_q, edge_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			edge_q  <= edge_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		edge_d       = edge_q;
		in_ready     = 1'b0;
		ctl          = '0;
		ctl.edge_sel = edge_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.rst_cmd) begin
						ctl.load_reset = 1'b1;
					end else begin
						ctl.load_tick = 1'b1;
						edge_d        = 1'b0;
						state_d       = ST_EDGE;
					end
				end
			end
			ST_EDGE: begin
				ctl.edge_start = 1'b1;
				if (sts.edge_hit) begin
					state_d = ST_DIV;
				end else if (edge_q) begin
					state_d = ST_MIX;
				end else begin
					edge_d = 1'b1;
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				ctl.sq_acc = 1'b1;
				if (edge_q) begin
					state_d = ST_MIX;
				end else begin
					edge_d  = 1'b1;
					state_d = ST_EDGE;
				end
			end
			ST_MIX: begin
				ctl.mix = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Divider runs its full length before squaring
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> state_q == ST_DIV)
		else $error("divider left early");

	// A finished sample never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> sts.out_free)
		else $error("commit while output register full");

	// Both edges are tested before the mix step of a tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX) |-> edge_q)
		else $error("mix reached before both edges");

endmodule

// ===== src/pbt_dp.sv =====
// Datapath of the triangle oscillator: phase and integrator state, edge
// tests, shared restoring divider, squarer, leaky integrator, output register.
// Depends on pbt_pkg for ctl_t and sts_t.
module pbt_dp #(
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbt_pkg::ctl_t                 ctl,
	output pbt_pkg::sts_t                 sts,
	input  logic                          cmd,
	input  logic [PHASE_BITS-1:0]         phase_step,
	input  logic [PHASE_BITS-1:0]         new_phase,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample
);
	import pbt_pkg::*;

	localparam int P    = PHASE_BITS;
	localparam int S    = SAMPLE_BITS;
	localparam int XW   = P + 3;
	localparam int CW   = $clog2(P);
	localparam int SH   = P - (S - 3);
	localparam int SHR  = (SH > 0) ? SH : 0;
	localparam int SHL  = (SH < 0) ? -SH : 0;
	localparam int XMW0 = P + 2 + SHL;
	localparam int XMW  = (XMW0 > S) ? XMW0 : S;
	localparam int PMW  = P + S + 1;

	localparam logic [XW-1:0] X_POS  = {3'b001, {P{1'b0}}};
	localparam logic [XW-1:0] X_NEG  = {3'b111, {P{1'b0}}};
	localparam logic [P:0]    ONE_P1 = {1'b1, {P{1'b0}}};

	logic [P-1:0]          phase_q;
	logic signed [S-1:0]   integ_q;
	logic                  out_valid_q;
	logic signed [S-1:0]   out_q;
	logic [P-1:0]          step_q;
	logic [XW-1:0]         x_q;
	logic [P-1:0]          rem_q;
	logic [P-1:0]          quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  kind_q;
	logic                  neg_q;
	logic [S:0]            mag_q;
	logic [S:0]            prod_q;

	// Edge test
	logic [P-1:0] t_pt;
	logic [P:0]   t_sum;
	logic         step_nz, hit_rise, hit_fall;
	logic [P-1:0] div_num;

	// Divider step
	logic [P:0] rem_sh;
	logic       rem_ge;

	// Squarer
	logic [P-1:0]   r_val;
	logic [2*P-1:0] sq_full;
	logic [P:0]     sq_val;
	logic [XW-1:0]  sq_ext;

	// Truncation and integrator difference
	logic          x_neg;
	logic [XW-1:0] x_abs;
	logic [XMW-1:0] xm_wide;
	logic [S-1:0]   xf_mag;
	logic [S+1:0]   xf_ext, integ_ext, diff, diff_abs;

	// Product and update
	logic [PMW-1:0] prod_full;
	logic [S+1:0]   y_val;
	logic signed [S-1:0] y_sat;

	always_comb begin
		t_pt     = {phase_q[P-1] ^ ctl.edge_sel, phase_q[P-2:0]};
		t_sum    = {1'b0, t_pt} + {1'b0, step_q};
		step_nz  = |step_q;
		hit_rise = step_nz && (t_pt < step_q);
		hit_fall = step_nz && !hit_rise && (t_sum > ONE_P1);
		div_num  = hit_rise ? t_pt : (P'(0) - t_pt);

		rem_sh = {rem_q, 1'b0};
		rem_ge = rem_sh >= {1'b0, step_q};

		r_val   = P'(0) - quo_q;
		sq_full = (2*P)'(r_val) * (2*P)'(r_val);
		sq_val  = (quo_q == '0) ? ONE_P1 : {1'b0, sq_full[2*P-1:P]};
		sq_ext  = {2'b00, sq_val};

		x_neg     = x_q[XW-1];
		x_abs     = x_neg ? (XW'(0) - x_q) : x_q;
		xm_wide   = (XMW'(x_abs[P+1:0]) >> SHR) << SHL;
		xf_mag    = xm_wide[S-1:0];
		xf_ext    = x_neg ? ((S+2)'(0) - {2'b00, xf_mag}) : {2'b00, xf_mag};
		integ_ext = {{2{integ_q[S-1]}}, integ_q};
		diff      = xf_ext - integ_ext;
		diff_abs  = diff[S+1] ? ((S+2)'(0) - diff) : diff;

		prod_full = PMW'(step_q) * PMW'(mag_q);

		y_val = neg_q ? (integ_ext - {1'b0, prod_q}) : (integ_ext + {1'b0, prod_q});
		if (y_val[S+1:S-1] == 3'b000 || y_val[S+1:S-1] == 3'b111) begin
			y_sat = y_val[S-1:0];
		end else if (y_val[S+1]) begin
			y_sat = {1'b1, {(S-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(S-1){1'b1}}};
		end
	end

	// Architectural state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_reset) begin
				phase_q <= new_phase;
				integ_q <= '0;
			end
			if (ctl.commit) begin
				phase_q     <= phase_q + step_q;
				integ_q     <= y_sat;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctl.load_tick) begin
			step_q <= phase_step;
			x_q    <= phase_q[P-1] ? X_NEG : X_POS;
		end
		if (ctl.edge_start) begin
			rem_q  <= div_num;
			quo_q  <= '0;
			cnt_q  <= '0;
			kind_q <= hit_fall;
		end
		if (ctl.div_step) begin
			rem_q <= rem_ge ? P'(rem_sh - {1'b0, step_q}) : rem_sh[P-1:0];
			quo_q <= {quo_q[P-2:0], rem_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctl.sq_acc) begin
			// edge_sel clear: rising hit subtracts, falling adds; edge_sel set inverts both
			x_q <= (kind_q ^ ctl.edge_sel) ? (x_q + sq_ext) : (x_q - sq_ext);
		end
		if (ctl.mix) begin
			neg_q <= diff[S+1];
			mag_q <= diff_abs[S:0];
		end
		if (ctl.mul) begin
			prod_q <= prod_full[PMW-1:P];
		end
		if (ctl.commit) begin
			out_q <= y_sat;
		end
	end

	assign sts.rst_cmd  = cmd;
	assign sts.edge_hit = hit_rise || hit_fall;
	assign sts.div_last = (cnt_q == CW'(P - 1));
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign sample       = out_q;

	// Partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_step |-> rem_q < step_q)
		else $error("divider remainder out of range");

	// Reset item loads the phase and clears the integrator
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_reset |=> (phase_q == $past(new_phase)) && (integ_q == '0))
		else $error("reset item not applied");

	// Phase advances by exactly the step on each sample
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> phase_q == $past(P'(phase_q + step_q)))
		else $error("phase advance mismatch");

endmodule
